FILE: design/rcti_pkg.sv
// Package for the rectangle clipper with texture-coordinate interpolation.
// Widths, pipeline constants, shared types and the saturation helper.
// No dependencies.
`default_nettype none
package rcti_pkg;

  localparam int COORD_W = 32;
  localparam int FRAC_W  = 16;
  localparam int MAG_W   = COORD_W + 1;
  localparam int PROD_W  = FRAC_W + MAG_W;
  localparam int CFG_IDX_W = 3;
  localparam int N_EDGE  = 4;
  localparam int OUT_LAT = FRAC_W + 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT   = 3'd0,
    CFG_TOP    = 3'd1,
    CFG_RIGHT  = 3'd2,
    CFG_BOTTOM = 3'd3
  } cfg_idx_t;

  localparam int EDGE_L = 0;
  localparam int EDGE_R = 1;
  localparam int EDGE_T = 2;
  localparam int EDGE_B = 3;

  typedef struct packed {
    logic [COORD_W-1:0] num;
    logic [COORD_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                culled;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [COORD_W-1:0]  w;
    logic [COORD_W-1:0]  h;
    logic [COORD_W-1:0]  s1;
    logic [COORD_W-1:0]  t1;
    logic [COORD_W-1:0]  s2;
    logic [COORD_W-1:0]  t2;
    logic [N_EDGE-1:0]   en;
  } payload_t;

  function automatic logic [COORD_W-1:0] sat_coord(input logic [COORD_W+1:0] v);
    logic [COORD_W-1:0] res;
    if ((v[COORD_W+1:COORD_W-1] == 3'b000) || (v[COORD_W+1:COORD_W-1] == 3'b111)) begin
      res = v[COORD_W-1:0];
    end else if (v[COORD_W+1]) begin
      res = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: design/rcti_setup.sv
// Entry stage: bounds, cull test, edge selection and divider operands.
// Depends on rcti_pkg.
`default_nettype none
module rcti_setup
  import rcti_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      acc,
  input  wire logic [COORD_W-1:0]        cl,
  input  wire logic [COORD_W-1:0]        ct,
  input  wire logic [COORD_W-1:0]        cr,
  input  wire logic [COORD_W-1:0]        cb,
  input  wire logic [COORD_W-1:0]        x,
  input  wire logic [COORD_W-1:0]        y,
  input  wire logic [COORD_W-1:0]        w,
  input  wire logic [COORD_W-1:0]        h,
  input  wire logic [COORD_W-1:0]        s1,
  input  wire logic [COORD_W-1:0]        t1,
  input  wire logic [COORD_W-1:0]        s2,
  input  wire logic [COORD_W-1:0]        t2,
  output logic                           vld_r,
  output payload_t                       pl_r,
  output div_req_t [N_EDGE-1:0]          req_r
);

  logic signed [COORD_W:0]   x33, y33, cl33, ct33, cr33, cb33, right, bottom;
  logic signed [COORD_W:0]   nx33, ny33, rlim, blim;
  logic [COORD_W+1:0]        nw34, nh34;
  logic                      clip_en, cull, act;
  logic [N_EDGE-1:0]         en;
  payload_t                  pl_nxt;
  div_req_t [N_EDGE-1:0]     req_nxt;

  always_comb begin
    x33    = {x[COORD_W-1], x};
    y33    = {y[COORD_W-1], y};
    cl33   = {cl[COORD_W-1], cl};
    ct33   = {ct[COORD_W-1], ct};
    cr33   = {cr[COORD_W-1], cr};
    cb33   = {cb[COORD_W-1], cb};
    right  = x33 + {w[COORD_W-1], w};
    bottom = y33 + {h[COORD_W-1], h};

    clip_en = (cr33 > cl33) && (cb33 > ct33);
    cull    = clip_en && ((right <= cl33) || (x33 >= cr33) ||
                          (bottom <= ct33) || (y33 >= cb33));
    act     = clip_en && !cull;

    en[EDGE_L] = act && (x33 < cl33);
    en[EDGE_R] = act && (right > cr33);
    en[EDGE_T] = act && (y33 < ct33);
    en[EDGE_B] = act && (bottom > cb33);

    nx33 = en[EDGE_L] ? cl33 : x33;
    ny33 = en[EDGE_T] ? ct33 : y33;
    rlim = en[EDGE_R] ? cr33 : right;
    blim = en[EDGE_B] ? cb33 : bottom;
    nw34 = {rlim[COORD_W], rlim} - {nx33[COORD_W], nx33};
    nh34 = {blim[COORD_W], blim} - {ny33[COORD_W], ny33};

    req_nxt[EDGE_L].num = COORD_W'(cl33 - x33);
    req_nxt[EDGE_R].num = COORD_W'(right - cr33);
    req_nxt[EDGE_T].num = COORD_W'(ct33 - y33);
    req_nxt[EDGE_B].num = COORD_W'(bottom - cb33);
    req_nxt[EDGE_L].den = w;
    req_nxt[EDGE_R].den = w;
    req_nxt[EDGE_T].den = h;
    req_nxt[EDGE_B].den = h;

    pl_nxt.culled = cull;
    pl_nxt.en     = cull ? '0 : en;
    pl_nxt.x      = cull ? '0 : nx33[COORD_W-1:0];
    pl_nxt.y      = cull ? '0 : ny33[COORD_W-1:0];
    pl_nxt.w      = cull ? '0 : sat_coord(nw34);
    pl_nxt.h      = cull ? '0 : sat_coord(nh34);
    pl_nxt.s1     = cull ? '0 : s1;
    pl_nxt.t1     = cull ? '0 : t1;
    pl_nxt.s2     = cull ? '0 : s2;
    pl_nxt.t2     = cull ? '0 : t2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    pl_r  <= pl_nxt;
    req_r <= req_nxt;
  end

endmodule
`default_nettype wire

FILE: design/rcti_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Gives the truncated fraction num/den for num < den. Depends on rcti_pkg.
`default_nettype none
module rcti_div
  import rcti_pkg::*;
(
  input  wire logic     clk,
  input  div_req_t      req,
  output logic [FRAC_W-1:0] q
);

  logic [COORD_W-1:0] rem_r [FRAC_W];
  logic [COORD_W-1:0] den_r [FRAC_W];
  logic [FRAC_W-1:0]  q_r   [FRAC_W];

  for (genvar k = 0; k < FRAC_W; k++) begin : g_stg
    logic [COORD_W-1:0] rem_src, den_src, rem_nxt;
    logic [FRAC_W-1:0]  q_src;
    logic [COORD_W:0]   sh;
    logic               ge;

    if (k == 0) begin : g_first
      assign rem_src = req.num;
      assign den_src = req.den;
      assign q_src   = '0;
    end else begin : g_next
      assign rem_src = rem_r[k-1];
      assign den_src = den_r[k-1];
      assign q_src   = q_r[k-1];
    end

    always_comb begin
      sh      = {rem_src, 1'b0};
      ge      = sh >= {1'b0, den_src};
      rem_nxt = ge ? COORD_W'(sh - {1'b0, den_src}) : sh[COORD_W-1:0];
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= rem_nxt;
      den_r[k] <= den_src;
      q_r[k]   <= {q_src[FRAC_W-2:0], ge};
    end
  end

  assign q = q_r[FRAC_W-1];

endmodule
`default_nettype wire

FILE: design/rcti_lerp.sv
// Three-stage interpolator: difference, fraction product, add and saturate.
// Depends on rcti_pkg.
`default_nettype none
module rcti_lerp
  import rcti_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic [FRAC_W-1:0]   f,
  input  wire logic [COORD_W-1:0]  near_c,
  input  wire logic [COORD_W-1:0]  far_c,
  output logic [COORD_W-1:0]       res_r
);

  logic [MAG_W-1:0]   diff, mag_r;
  logic               neg_r, neg2_r, en_r, en2_r;
  logic [FRAC_W-1:0]  f_r;
  logic [COORD_W-1:0] near_r, near2_r;
  logic [PROD_W-1:0]  prod_r;
  logic [MAG_W:0]     term;
  logic [COORD_W+1:0] sum;
  logic [COORD_W-1:0] res_nxt;

  always_comb begin
    diff = {far_c[COORD_W-1], far_c} - {near_c[COORD_W-1], near_c};
  end

  always_ff @(posedge clk) begin
    neg_r  <= diff[MAG_W-1];
    mag_r  <= diff[MAG_W-1] ? MAG_W'(-diff) : diff;
    f_r    <= f;
    near_r <= near_c;
    en_r   <= en;
  end

  always_ff @(posedge clk) begin
    prod_r  <= PROD_W'(f_r) * PROD_W'(mag_r);
    neg2_r  <= neg_r;
    near2_r <= near_r;
    en2_r   <= en_r;
  end

  always_comb begin
    term    = {1'b0, prod_r[PROD_W-1:FRAC_W]};
    if (neg2_r) begin
      term = (MAG_W+1)'(-term);
    end
    sum     = {{2{near2_r[COORD_W-1]}}, near2_r} + term;
    res_nxt = en2_r ? sat_coord(sum) : near2_r;
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule
`default_nettype wire

FILE: design/rect_clip_texcoord_interp_core.sv
// Pipeline depth: the 16-stage fraction divider plus entry and 3 interpolation stages.
// One request per cycle; busy is low except while rst_n is asserted; no receiver stall.
// Synchronous active-low reset clears valid bits and clip registers to 0.
// Depends on rcti_pkg, rcti_setup, rcti_div, rcti_lerp.
`default_nettype none
module rect_clip_texcoord_interp_core
  import rcti_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [COORD_W-1:0]    in_pos_x,
  input  wire logic [COORD_W-1:0]    in_pos_y,
  input  wire logic [COORD_W-1:0]    in_width,
  input  wire logic [COORD_W-1:0]    in_height,
  input  wire logic [COORD_W-1:0]    in_tex_s1,
  input  wire logic [COORD_W-1:0]    in_tex_t1,
  input  wire logic [COORD_W-1:0]    in_tex_s2,
  input  wire logic [COORD_W-1:0]    in_tex_t2,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [COORD_W-1:0]    cfg_data,
  output logic                       out_valid,
  output logic                       out_culled,
  output logic [COORD_W-1:0]         out_x,
  output logic [COORD_W-1:0]         out_y,
  output logic [COORD_W-1:0]         out_width,
  output logic [COORD_W-1:0]         out_height,
  output logic [COORD_W-1:0]         out_s1,
  output logic [COORD_W-1:0]         out_t1,
  output logic [COORD_W-1:0]         out_s2,
  output logic [COORD_W-1:0]         out_t2
);

  logic [COORD_W-1:0]     cl_r, ct_r, cr_r, cb_r;
  logic                   acc;
  logic                   s_vld;
  payload_t               s_pl;
  div_req_t [N_EDGE-1:0]  s_req;
  logic [FRAC_W-1:0]      q [N_EDGE];
  logic [COORD_W-1:0]     near_c [N_EDGE];
  logic [COORD_W-1:0]     far_c  [N_EDGE];
  logic [COORD_W-1:0]     res [N_EDGE];
  payload_t               pl_r  [1:OUT_LAT-1];
  logic                   vld_r [1:OUT_LAT-1];

  assign busy      = !rst_n;
  assign cfg_ready = 1'b1;
  assign acc       = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cl_r <= '0;
      ct_r <= '0;
      cr_r <= '0;
      cb_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LEFT:   cl_r <= cfg_data;
        CFG_TOP:    ct_r <= cfg_data;
        CFG_RIGHT:  cr_r <= cfg_data;
        CFG_BOTTOM: cb_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rcti_setup u_setup (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .cl    (cl_r),
    .ct    (ct_r),
    .cr    (cr_r),
    .cb    (cb_r),
    .x     (in_pos_x),
    .y     (in_pos_y),
    .w     (in_width),
    .h     (in_height),
    .s1    (in_tex_s1),
    .t1    (in_tex_t1),
    .s2    (in_tex_s2),
    .t2    (in_tex_t2),
    .vld_r (s_vld),
    .pl_r  (s_pl),
    .req_r (s_req)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k < OUT_LAT; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else begin
      vld_r[1] <= s_vld;
      for (int k = 2; k < OUT_LAT; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    pl_r[1] <= s_pl;
    for (int k = 2; k < OUT_LAT; k++) begin
      pl_r[k] <= pl_r[k-1];
    end
  end

  always_comb begin
    near_c[EDGE_L] = pl_r[FRAC_W].s1;
    far_c[EDGE_L]  = pl_r[FRAC_W].s2;
    near_c[EDGE_R] = pl_r[FRAC_W].s2;
    far_c[EDGE_R]  = pl_r[FRAC_W].s1;
    near_c[EDGE_T] = pl_r[FRAC_W].t1;
    far_c[EDGE_T]  = pl_r[FRAC_W].t2;
    near_c[EDGE_B] = pl_r[FRAC_W].t2;
    far_c[EDGE_B]  = pl_r[FRAC_W].t1;
  end

  for (genvar e = 0; e < N_EDGE; e++) begin : g_edge
    rcti_div u_div (
      .clk (clk),
      .req (s_req[e]),
      .q   (q[e])
    );

    rcti_lerp u_lerp (
      .clk    (clk),
      .en     (pl_r[FRAC_W].en[e]),
      .f      (q[e]),
      .near_c (near_c[e]),
      .far_c  (far_c[e]),
      .res_r  (res[e])
    );
  end

  assign out_valid  = vld_r[OUT_LAT-1];
  assign out_culled = pl_r[OUT_LAT-1].culled;
  assign out_x      = pl_r[OUT_LAT-1].x;
  assign out_y      = pl_r[OUT_LAT-1].y;
  assign out_width  = pl_r[OUT_LAT-1].w;
  assign out_height = pl_r[OUT_LAT-1].h;
  assign out_s1     = res[EDGE_L];
  assign out_s2     = res[EDGE_R];
  assign out_t1     = res[EDGE_T];
  assign out_t2     = res[EDGE_B];

endmodule
`default_nettype wire

FILE: design/rcti_chk.sv
// Port-level checker for the clipper core, bound to the top level.
// Depends on rcti_pkg and rect_clip_texcoord_interp_core.
`default_nettype none
module rcti_chk
  import rcti_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  start,
  input wire logic                  busy,
  input wire logic                  cfg_ready,
  input wire logic                  out_valid,
  input wire logic                  out_culled,
  input wire logic [COORD_W-1:0]    out_x,
  input wire logic [COORD_W-1:0]    out_y,
  input wire logic [COORD_W-1:0]    out_width,
  input wire logic [COORD_W-1:0]    out_height,
  input wire logic [COORD_W-1:0]    out_s1,
  input wire logic [COORD_W-1:0]    out_t1,
  input wire logic [COORD_W-1:0]    out_s2,
  input wire logic [COORD_W-1:0]    out_t2
);

  a_resp_follows_req: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##OUT_LAT out_valid)
    else $error("request without result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, OUT_LAT))
    else $error("result without request");

  a_culled_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_culled) |-> (out_x == '0 && out_y == '0 && out_width == '0 &&
      out_height == '0 && out_s1 == '0 && out_t1 == '0 && out_s2 == '0 && out_t2 == '0))
    else $error("culled result carries data");

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && cfg_ready)
    else $error("busy outside reset");

endmodule

bind rect_clip_texcoord_interp_core rcti_chk u_rcti_chk (.*);
`default_nettype wire
